// ===== design/cmod_pkg.sv =====
// ----------------------------------------------------------------------------
// cmod_pkg
// Shared types and constants for the carrier/modulator logic block.
// ----------------------------------------------------------------------------
package cmod_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned CFG_W    = 32;

    // Register map, indexed by word address (paddr[2])
    localparam logic [0:0] REG_OFFSET_AMOUNT = 1'b0;

    localparam logic [SAMPLE_W-1:0] OFFSET_AMOUNT_RESET = 16'h8000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Input transfer payload, first field in the high bits
    typedef struct packed {
        sample_t modulator_sample;
        sample_t carrier_sample;
    } in_item_t;

    // Result transfer payload, first field in the high bits
    typedef struct packed {
        sample_t positive_offset_read;
        sample_t offset_read;
        sample_t rectified_scaled;
        sample_t rectified_abs_scaled;
        sample_t rectified;
        sample_t polarity_gate;
        sample_t positive_gate;
        sample_t greater_gate;
    } result_t;

endpackage

// ===== design/carrier_modulator_logic_and_offset_read.sv =====
// ----------------------------------------------------------------------------
// carrier_modulator_logic_and_offset_read
// Delays carrier/modulator pairs by one block through two memory banks and
// derives gates, rectified products and modulator-driven offset reads.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                   payload
//  s_*      in   s_tvalid / s_tready         s_tdata: carrier, modulator
//  m_*      out  m_tvalid / m_tready         m_tdata: eight Q1.15 results
//  apb      in   psel, penable, pwrite       offset_amount at byte 0
//
//  Each item steps through reading the delayed pair, a multiply step, then
//  the two offset reads, serialized on the single carrier memory read port,
//  and the final output load; no new item is taken until the sequencer is idle.
//  After reset or a register write, input transfers wait while the offset
//  scale pipeline (p*p, *p, *FRAMES/2) settles.
//  Reset needs no clearing pass: reads during the first block are forced
//  to zero. A stalled output holds the sequencer in its last state.
// ----------------------------------------------------------------------------
module carrier_modulator_logic_and_offset_read #(
    parameter int unsigned FRAMES = 512
) (
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // carrier_sample, modulator_sample
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // greater_gate, positive_gate, polarity_gate,
                                    // rectified, rectified_abs_scaled,
                                    // rectified_scaled, offset_read,
                                    // positive_offset_read
);

    localparam int unsigned POS_W  = (FRAMES > 2) ? $clog2(FRAMES) : 1;
    localparam int unsigned ADDR_W = POS_W + 1;
    localparam int unsigned DEPTH  = 2 ** ADDR_W;
    localparam int unsigned AQ_W   = POS_W + 16;
    localparam int unsigned PROD_W = AQ_W + 18;
    localparam int unsigned OFS_W  = POS_W + 2;
    localparam int unsigned GAIN_W = 34;

    localparam logic [POS_W-1:0] HALF     = POS_W'(FRAMES / 2);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAMES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_IDX1 = 3'd3;
    localparam logic [2:0] S_IDX2 = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [15:0] offset_amount_reg;
    logic [1:0]  settle_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == cmod_pkg::REG_OFFSET_AMOUNT);

    always_comb
    begin
        prdata = '0;
        if (paddr[2:2] == cmod_pkg::REG_OFFSET_AMOUNT)
        begin
            prdata = {16'h0000, offset_amount_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_amount_reg <= cmod_pkg::OFFSET_AMOUNT_RESET;
            settle_reg        <= SETTLE_CYCLES;
        end
        else if (cfg_wr)
        begin
            offset_amount_reg <= pwdata[15:0];
            settle_reg        <= SETTLE_CYCLES;
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    // Offset scale: aq = floor(FRAMES/2 * p^3 / 2^32)
    logic [31:0]         p2_reg;
    logic [47:0]         p3_reg;
    logic [AQ_W-1:0]     aq_reg;
    logic [48+POS_W-1:0] aq_full;

    assign aq_full = (48 + POS_W)'(p3_reg) * (48 + POS_W)'(HALF);

    always_ff @(posedge clk)
    begin
        p2_reg <= 32'(offset_amount_reg) * 32'(offset_amount_reg);
        p3_reg <= 48'(p2_reg) * 48'(offset_amount_reg);
        aq_reg <= aq_full[32 +: AQ_W];
    end

    // ------------------------------------------------------------------
    // Sequencer and frame position
    // ------------------------------------------------------------------
    logic [2:0]       state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             bank_reg, bank_next;
    logic             first_reg, first_next;
    logic             out_valid_reg, out_valid_next;
    logic [127:0]     out_data_reg, out_data_next;
    logic             in_xfer;
    logic             out_free;

    cmod_pkg::in_item_t in_item;
    cmod_pkg::result_t  res;

    assign in_item  = s_tdata;
    assign s_tready = (state_reg == S_IDLE) && (settle_reg == '0);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Memories: bank select in the top address bit
    // ------------------------------------------------------------------
    logic signed [15:0] carrier_mem [DEPTH];
    logic signed [15:0] modulator_mem [DEPTH];
    logic signed [15:0] crd_reg;
    logic signed [15:0] mrd_reg;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  craddr;
    logic               cre;
    logic [POS_W-1:0]   idx_clamped;

    assign waddr = {bank_reg, pos_reg};

    always_comb
    begin
        cre    = in_xfer;
        craddr = {~bank_reg, pos_reg};
        if (state_reg == S_IDX1 || state_reg == S_IDX2)
        begin
            cre    = 1'b1;
            craddr = {~bank_reg, idx_clamped};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            carrier_mem[waddr]   <= in_item.carrier_sample;
            modulator_mem[waddr] <= in_item.modulator_sample;
            mrd_reg              <= modulator_mem[{~bank_reg, pos_reg}];
        end
        if (cre)
        begin
            crd_reg <= carrier_mem[craddr];
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic signed [15:0]       c_reg, m_reg;
    logic [15:0]              ac, am;
    logic [17:0]              r_wide;
    logic signed [16:0]       r_s;
    logic signed [16:0]       off_a, gain_b;
    logic signed [AQ_W:0]     aq_s;
    logic signed [PROD_W-1:0] off_prod_reg;
    logic signed [GAIN_W-1:0] gain_prod_reg;
    logic signed [PROD_W-1:0] off_biased, off_sh1, off_sh2;
    logic signed [OFS_W-1:0]  off_sel, idx_sum;
    logic signed [GAIN_W-1:0] gain_biased, gain_sh;
    logic signed [15:0]       gain_sat;
    logic signed [15:0]       rs_scaled_reg, rs_abs_reg, off_read_reg;

    assign ac     = c_reg[15] ? 16'(-c_reg) : c_reg;
    assign am     = m_reg[15] ? 16'(-m_reg) : m_reg;
    assign r_wide = {1'b0, ac, 1'b0} - 18'h08000;
    assign r_s    = $signed(r_wide[16:0]);
    assign aq_s   = $signed({1'b0, aq_reg});

    // m for the bipolar read, m + 32768 for the unipolar one
    assign off_a  = (state_reg == S_MUL) ? 17'(m_reg) : $signed({1'b0, ~m_reg[15], m_reg[14:0]});
    assign gain_b = (state_reg == S_MUL) ? 17'(m_reg) : $signed({1'b0, am});

    // Truncate toward zero: bias negatives before the arithmetic shift
    assign off_biased = off_prod_reg[PROD_W-1]
                        ? off_prod_reg + $signed({{(PROD_W-31){1'b0}}, {31{1'b1}}})
                        : off_prod_reg;
    assign off_sh1    = off_biased >>> 31;
    assign off_sh2    = off_prod_reg >>> 32;
    assign off_sel    = (state_reg == S_IDX1) ? off_sh1[OFS_W-1:0] : off_sh2[OFS_W-1:0];
    assign idx_sum    = $signed({2'b00, pos_reg}) + off_sel;

    always_comb
    begin
        if (idx_sum[OFS_W-1])
        begin
            idx_clamped = '0;
        end
        else if (idx_sum > $signed({2'b00, LAST_POS}))
        begin
            idx_clamped = LAST_POS;
        end
        else
        begin
            idx_clamped = idx_sum[POS_W-1:0];
        end
    end

    assign gain_biased = gain_prod_reg[GAIN_W-1]
                         ? gain_prod_reg + $signed(GAIN_W'(32767))
                         : gain_prod_reg;
    assign gain_sh     = gain_biased >>> 15;
    // only +32768 can leave the range
    assign gain_sat    = (gain_sh > $signed(GAIN_W'(32767))) ? 16'sh7FFF : gain_sh[15:0];

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_LOAD:
            begin
                c_reg <= first_reg ? 16'sd0 : crd_reg;
                m_reg <= first_reg ? 16'sd0 : mrd_reg;
            end
            S_MUL:
            begin
                off_prod_reg  <= off_a * aq_s;
                gain_prod_reg <= r_s * gain_b;
            end
            S_IDX1:
            begin
                off_prod_reg  <= off_a * aq_s;
                gain_prod_reg <= r_s * gain_b;
                rs_scaled_reg <= gain_sat;
            end
            S_IDX2:
            begin
                rs_abs_reg   <= gain_sat;
                off_read_reg <= crd_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Result assembly
    always_comb
    begin
        res.greater_gate         = (ac > am) ? c_reg : 16'sd0;
        res.positive_gate        = (m_reg > 16'sd0) ? c_reg : 16'sd0;
        res.polarity_gate        = ((c_reg > 16'sd0 && m_reg > 16'sd0)
                                    || (c_reg < 16'sd0 && m_reg < 16'sd0)) ? c_reg : 16'sd0;
        res.rectified            = (r_s > 17'sd32767) ? 16'sh7FFF : r_s[15:0];
        res.rectified_abs_scaled = rs_abs_reg;
        res.rectified_scaled     = rs_scaled_reg;
        res.offset_read          = first_reg ? 16'sd0 : off_read_reg;
        res.positive_offset_read = first_reg ? 16'sd0 : crd_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        bank_next      = bank_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: state_next = S_MUL;
            S_MUL:  state_next = S_IDX1;
            S_IDX1: state_next = S_IDX2;
            S_IDX2: state_next = S_DONE;
            S_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res;
                    state_next     = S_IDLE;
                    if (pos_reg == LAST_POS)
                    begin
                        pos_next   = '0;
                        bank_next  = ~bank_reg;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            bank_reg      <= 1'b0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            bank_reg      <= bank_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE || settle_reg != '0) |-> !s_tready)
        else $error("input accepted while busy or settling");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside the final step");

    a_first_block_once: assert property (@(posedge clk) disable iff (!rst_n)
        !first_reg |=> !first_reg)
        else $error("first block flag set again");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("frame position out of range");

    a_bank_flip_at_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> (pos_reg == '0 && $past(pos_reg) == LAST_POS))
        else $error("bank swapped away from the block boundary");

endmodule
